@@ hw/rtl/temq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temq_pkg: shared definitions for the timed event match queue
// Operation and status codes, the stored event record and default sizes.
// ----------------------------------------------------------------------------
package temq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 32;

    // Operation codes carried on the op port.
    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    // Removal count port width and its saturation value.
    localparam int         COUNT_W   = 6;
    localparam logic [5:0] COUNT_MAX = 6'd63;

    // One stored event.
    typedef struct packed {
        logic [31:0] module_h;
        logic [31:0] call_h;
        logic [31:0] prim_h;
        logic [63:0] due;
        logic [31:0] payload;
    } entry_t;

endpackage

@@ hw/rtl/temq_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temq_table: event storage
// Simple dual-port table with one write port and one registered read port.
// ----------------------------------------------------------------------------
module temq_table #(
    parameter int DEPTH = temq_pkg::DEFAULT_QUEUE_DEPTH,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  temq_pkg::entry_t     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output temq_pkg::entry_t     rd_data
);
    import temq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/timed_event_match_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_match_queue: insertion-ordered queue of timed events
// Push, pop-oldest-due-match and cancel-by-primitive over a compacted table.
// ----------------------------------------------------------------------------
// Usage
//   A command transfer happens at a rising edge where start is high and busy
//   is low; op and the key/event fields are sampled at that edge. Each
//   command produces exactly one result: done is high for one cycle and the
//   result ports are valid in that same cycle. The receiver cannot hold a
//   result off, so it must take it in that cycle.
//   A push writes the event straight into the table; its result follows in
//   the cycle after the transfer and busy never rises. The unused op code
//   behaves the same way with an all-zero result.
//   Pop and cancel walk the live entries through the single read port of
//   the table, one entry per cycle, and write kept entries back down to
//   close gaps. Busy stays high from the transfer until the walk has ended;
//   done follows in the next cycle, in which a new command may already be
//   transferred. The rate is set by that one-entry-per-cycle walk through
//   the table port and the shared match compare.
//   Reset clears the entry count and the sequencer; table contents are not
//   cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module timed_event_match_queue #(
    parameter int QUEUE_DEPTH = temq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [31:0] module_handle,
    input  logic [31:0] call_handle,
    input  logic [31:0] primitive_handle,
    input  logic [63:0] due_time,
    input  logic [31:0] payload_ref,
    input  logic [63:0] now_time,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] out_module,
    output logic [31:0] out_call,
    output logic [31:0] out_primitive,
    output logic [63:0] out_due_time,
    output logic [31:0] out_payload_ref,
    output logic [5:0]  removed_count
);
    import temq_pkg::*;

    localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t      state_reg;
    logic [1:0]  op_reg;
    logic [31:0] key_module_reg;
    logic [31:0] key_call_reg;
    logic [31:0] key_prim_reg;
    logic [63:0] now_reg;

    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] keep_reg;
    logic [CNT_W-1:0] removed_reg;
    logic             pend_reg;
    logic             found_reg;
    entry_t           hit_reg;

    logic        done_reg;
    logic [1:0]  status_reg;
    logic [31:0] out_module_reg;
    logic [31:0] out_call_reg;
    logic [31:0] out_prim_reg;
    logic [63:0] out_due_reg;
    logic [31:0] out_payload_reg;
    logic [5:0]  removed_count_reg;

    logic              full;
    logic              rd_en;
    logic              key_match;
    logic              drop;
    logic              scan_end;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
    entry_t            push_entry;
    entry_t            rd_data;
    logic [31:0]       removed_wide;
    logic [5:0]        removed_sat;

    assign full = (used_reg >= CNT_W'(QUEUE_DEPTH));

    assign push_entry = '{module_h: module_handle, call_h: call_handle,
                          prim_h: primitive_handle, due: due_time,
                          payload: payload_ref};

    // Walk control: a read is issued while entries remain, and the data of
    // the previous read is judged in the following cycle.
    assign rd_en    = (state_reg == S_SCAN) && (rd_idx_reg < used_reg);
    assign scan_end = (state_reg == S_SCAN) && !rd_en && !pend_reg;

    // Shared match unit: handle equality plus the due-time compare.
    assign key_match = (rd_data.module_h == key_module_reg)
                    && (rd_data.call_h == key_call_reg)
                    && (rd_data.due <= now_reg);

    // An entry leaves the table when it is the first due match of a pop or
    // when its primitive handle matches a cancel.
    assign drop = pend_reg
               && (((op_reg == OP_CANCEL) && (rd_data.prim_h == key_prim_reg))
                || ((op_reg == OP_POP) && !found_reg && key_match));

    // In idle the write port serves pushes; during a walk it writes each kept
    // entry down to the next free position, which closes any gap.
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            wr_en   = start && (op == OP_PUSH) && !full;
            wr_addr = used_reg[ADDR_W-1:0];
            wr_data = push_entry;
        end
        else
        begin
            wr_en   = pend_reg && !drop;
            wr_addr = keep_reg[ADDR_W-1:0];
            wr_data = rd_data;
        end
    end

    assign removed_wide = 32'(removed_reg);
    assign removed_sat  = (removed_wide > 32'(COUNT_MAX)) ? COUNT_MAX
                                                          : removed_wide[5:0];

    temq_table #(
        .DEPTH (QUEUE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // The entry found by a pop is held until the result is formed.
    always_ff @(posedge clk)
    begin
        if (drop && (op_reg == OP_POP))
        begin
            hit_reg <= rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            op_reg            <= OP_PUSH;
            key_module_reg    <= '0;
            key_call_reg      <= '0;
            key_prim_reg      <= '0;
            now_reg           <= '0;
            used_reg          <= '0;
            rd_idx_reg        <= '0;
            keep_reg          <= '0;
            removed_reg       <= '0;
            pend_reg          <= 1'b0;
            found_reg         <= 1'b0;
            done_reg          <= 1'b0;
            status_reg        <= ST_OK;
            out_module_reg    <= '0;
            out_call_reg      <= '0;
            out_prim_reg      <= '0;
            out_due_reg       <= '0;
            out_payload_reg   <= '0;
            removed_count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg            <= op;
                        key_module_reg    <= module_handle;
                        key_call_reg      <= call_handle;
                        key_prim_reg      <= primitive_handle;
                        now_reg           <= now_time;
                        out_module_reg    <= '0;
                        out_call_reg      <= '0;
                        out_prim_reg      <= '0;
                        out_due_reg       <= '0;
                        out_payload_reg   <= '0;
                        removed_count_reg <= '0;
                        unique case (op) inside
                            OP_PUSH:
                            begin
                                done_reg   <= 1'b1;
                                status_reg <= full ? ST_FULL : ST_OK;
                                if (!full)
                                begin
                                    used_reg <= used_reg + 1'b1;
                                end
                            end
                            OP_POP, OP_CANCEL:
                            begin
                                state_reg   <= S_SCAN;
                                rd_idx_reg  <= '0;
                                keep_reg    <= '0;
                                removed_reg <= '0;
                                pend_reg    <= 1'b0;
                                found_reg   <= 1'b0;
                            end
                            default:
                            begin
                                done_reg   <= 1'b1;
                                status_reg <= ST_OK;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    pend_reg <= rd_en;
                    if (rd_en)
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                    if (pend_reg)
                    begin
                        if (drop)
                        begin
                            removed_reg <= removed_reg + 1'b1;
                            if (op_reg == OP_POP)
                            begin
                                found_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            keep_reg <= keep_reg + 1'b1;
                        end
                    end
                    if (scan_end)
                    begin
                        state_reg <= S_IDLE;
                        used_reg  <= keep_reg;
                        done_reg  <= 1'b1;
                        if (op_reg == OP_POP)
                        begin
                            status_reg <= found_reg ? ST_OK : ST_NONE;
                            if (found_reg)
                            begin
                                out_module_reg  <= hit_reg.module_h;
                                out_call_reg    <= hit_reg.call_h;
                                out_prim_reg    <= hit_reg.prim_h;
                                out_due_reg     <= hit_reg.due;
                                out_payload_reg <= hit_reg.payload;
                            end
                        end
                        else
                        begin
                            status_reg        <= ST_OK;
                            removed_count_reg <= removed_sat;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign out_module      = out_module_reg;
    assign out_call        = out_call_reg;
    assign out_primitive   = out_prim_reg;
    assign out_due_time    = out_due_reg;
    assign out_payload_ref = out_payload_reg;
    assign removed_count   = removed_count_reg;

endmodule

@@ hw/rtl/temq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temq_checker: port-level checks for the timed event match queue
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module temq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  op,
    input logic        done,
    input logic [1:0]  status,
    input logic [31:0] out_module,
    input logic [5:0]  removed_count
);
    import temq_pkg::*;

    // A result is never delivered while a walk is still in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result delivered while busy");

    // Every accepted command either finishes at once or keeps the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted command produced neither result nor busy");

    // A full status can only answer a push transferred in the previous cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |->
            $past(start && !busy && (op == OP_PUSH)))
        else $error("full status without a preceding push");

    // A pop that found nothing returns no event and no count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_NONE)) |->
            ((out_module == 32'd0) && (removed_count == 6'd0)))
        else $error("empty pop result carries data");

endmodule

bind timed_event_match_queue temq_checker u_temq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .done          (done),
    .status        (status),
    .out_module    (out_module),
    .removed_count (removed_count)
);
